// ===== hw/rtl/owbms_pkg.sv =====
// ----------------------------------------------------------------------------
// owbms_pkg
// shared types, register indexes, op codes and reset values of the bus master
// ----------------------------------------------------------------------------
package owbms_pkg;

    localparam int TIME_BITS_DEF = 10;
    localparam int TIME_BITS_MAX = 16;
    localparam int CFG_DATA_W    = 10;
    localparam int NUM_REGS      = 8;
    localparam int REG_IDX_W     = 3;
    localparam int OP_W          = 2;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_RESET_LOW    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRESENCE     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RESET_REC    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SHORT_LOW    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LONG_LOW     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WRITE_SLOT   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SLOT_REC     = 3'd7;

    localparam int unsigned CFG_RESET [NUM_REGS] = '{480, 70, 420, 1, 80, 81, 15, 100};

    // op codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_RESET = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       present;
        logic [7:0] read_data;
        logic       rejected;
    } res_t;

endpackage

// ===== hw/rtl/owbms_seq.sv =====
// ----------------------------------------------------------------------------
// owbms_seq
// slot sequencer state and per-tick next state and result logic
// ----------------------------------------------------------------------------
module owbms_seq #(
    parameter int TIME_BITS = owbms_pkg::TIME_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step,
    input  logic [owbms_pkg::OP_W-1:0]          op,
    input  logic [7:0]                          wb,
    input  logic                                lvl,
    input  logic [TIME_BITS-1:0]                cfg [owbms_pkg::NUM_REGS],
    output owbms_pkg::res_t                     res
);

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_RST_LOW  = 3'd1;
    localparam logic [2:0] PH_RST_WAIT = 3'd2;
    localparam logic [2:0] PH_RST_REC  = 3'd3;
    localparam logic [2:0] PH_SLOT_LOW = 3'd4;
    localparam logic [2:0] PH_SLOT_REL = 3'd5;
    localparam logic [2:0] PH_SLOT_REC = 3'd6;
    localparam logic [2:0] PH_GAP      = 3'd7;

    logic [2:0]           phase_reg, phase_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [2:0]           bit_reg, bit_next;
    logic [7:0]           shift_reg, shift_next;
    logic                 reading_reg, reading_next;
    logic                 presence_reg, presence_next;

    function automatic logic [TIME_BITS-1:0] at_least_one(input logic [TIME_BITS-1:0] v);
        return (v == '0) ? TIME_BITS'(1) : v;
    endfunction

    always_comb begin
        logic [2:0]           cur_ph;
        logic [TIME_BITS-1:0] lo_len;
        logic [TIME_BITS-1:0] rel_len;
        logic [TIME_BITS-1:0] ph_len;
        logic [TIME_BITS-1:0] tc_inc;

        phase_next    = phase_reg;
        time_next     = time_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        reading_next  = reading_reg;
        presence_next = presence_reg;
        res           = '0;

        // command start or reject
        if (op != owbms_pkg::OP_TICK) begin
            if (phase_reg != PH_IDLE) begin
                res.rejected = 1'b1;
            end else begin
                time_next = '0;
                bit_next  = '0;
                if (op == owbms_pkg::OP_RESET) begin
                    phase_next = PH_RST_LOW;
                end else begin
                    reading_next = (op == owbms_pkg::OP_READ);
                    shift_next   = (op == owbms_pkg::OP_READ) ? 8'h00 : wb;
                    phase_next   = PH_SLOT_LOW;
                end
            end
        end

        cur_ph = phase_next;
        lo_len = (reading_next || shift_next[bit_next])
                 ? at_least_one(cfg[owbms_pkg::REG_SHORT_LOW])
                 : at_least_one(cfg[owbms_pkg::REG_LONG_LOW]);
        if (reading_next) begin
            rel_len = at_least_one(cfg[owbms_pkg::REG_READ_SAMPLE]);
        end else begin
            rel_len = (cfg[owbms_pkg::REG_WRITE_SLOT] > lo_len)
                      ? cfg[owbms_pkg::REG_WRITE_SLOT] - lo_len : '0;
        end

        unique case (cur_ph)
            PH_RST_LOW:  ph_len = at_least_one(cfg[owbms_pkg::REG_RESET_LOW]);
            PH_RST_WAIT: ph_len = at_least_one(cfg[owbms_pkg::REG_PRESENCE]);
            PH_RST_REC:  ph_len = at_least_one(cfg[owbms_pkg::REG_RESET_REC]);
            PH_SLOT_LOW: ph_len = lo_len;
            PH_SLOT_REL: ph_len = at_least_one(rel_len);
            default:     ph_len = at_least_one(cfg[owbms_pkg::REG_SLOT_REC]);
        endcase

        tc_inc = TIME_BITS'(time_next + 1'b1);

        if (cur_ph != PH_IDLE) begin
            res.busy      = 1'b1;
            res.drive_low = (cur_ph == PH_RST_LOW) || (cur_ph == PH_SLOT_LOW);
            if (tc_inc >= ph_len) begin
                time_next = '0;
                unique case (cur_ph)
                    PH_RST_LOW: begin
                        phase_next = PH_RST_WAIT;
                    end
                    PH_RST_WAIT: begin
                        presence_next = ~lvl;
                        phase_next    = PH_RST_REC;
                    end
                    PH_RST_REC: begin
                        phase_next = PH_IDLE;
                        res.done   = 1'b1;
                    end
                    PH_SLOT_LOW: begin
                        phase_next = (rel_len == '0) ? PH_SLOT_REC : PH_SLOT_REL;
                    end
                    PH_SLOT_REL: begin
                        if (reading_next) begin
                            shift_next = shift_next | (8'(lvl) << bit_next);
                        end
                        phase_next = PH_SLOT_REC;
                    end
                    PH_SLOT_REC: begin
                        if (bit_next == 3'd7) begin
                            if (reading_next) begin
                                phase_next = PH_GAP;
                            end else begin
                                phase_next = PH_IDLE;
                                res.done   = 1'b1;
                            end
                        end else begin
                            bit_next   = bit_next + 3'd1;
                            phase_next = PH_SLOT_LOW;
                        end
                    end
                    PH_GAP: begin
                        phase_next    = PH_IDLE;
                        res.done      = 1'b1;
                        res.read_data = shift_next;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end else begin
                time_next = tc_inc;
            end
        end

        res.present = presence_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            time_reg     <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            reading_reg  <= 1'b0;
            presence_reg <= 1'b0;
        end else if (step) begin
            phase_reg    <= phase_next;
            time_reg     <= time_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            reading_reg  <= reading_next;
            presence_reg <= presence_next;
        end
    end

endmodule

// ===== hw/rtl/onewire_bus_master_slots_unit.sv =====
// an accepted input item passes the input and result registers to the m_ side
// throughput: one item per cycle unless the m_ side stalls; s_ready follows m_ready
//   through two register stages (input register, result register), sequencer
//   state updates as an item moves from the first to the second
// reset: aresetn synchronous active low; clears sequencer state and both stage
//   valids, loads the timing registers with their default values
// ----------------------------------------------------------------------------
// onewire_bus_master_slots_unit
// one-wire bus master slot sequencer, one tick per item, with timing registers
// ----------------------------------------------------------------------------
module onewire_bus_master_slots_unit #(
    parameter int TIME_BITS = owbms_pkg::TIME_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [owbms_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [owbms_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [owbms_pkg::OP_W-1:0]          s_op,
    input  logic [7:0]                          s_write_byte,
    input  logic                                s_bus_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_drive_low,
    output logic                                m_busy_res,
    output logic                                m_op_done,
    output logic                                m_device_present,
    output logic [7:0]                          m_read_data,
    output logic                                m_rejected
);

    logic [TIME_BITS-1:0]                cfg_reg [owbms_pkg::NUM_REGS];
    logic [owbms_pkg::TIME_BITS_MAX-1:0] cfg_wide;

    logic                       in_valid_reg;
    logic [owbms_pkg::OP_W-1:0] op_reg;
    logic [7:0]                 wb_reg;
    logic                       lvl_reg;

    logic                       out_valid_reg;
    owbms_pkg::res_t            out_reg;
    owbms_pkg::res_t            res;
    logic                       advance;

    assign cfg_wide = owbms_pkg::TIME_BITS_MAX'(cfg_data);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < owbms_pkg::NUM_REGS; i++) begin
                cfg_reg[i] <= TIME_BITS'(owbms_pkg::CFG_RESET[i]);
            end
        end else if (cfg_wr_en) begin
            cfg_reg[cfg_index] <= cfg_wide[TIME_BITS-1:0];
        end
    end

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_op;
            wb_reg  <= s_write_byte;
            lvl_reg <= s_bus_level;
        end
    end

    owbms_seq #(
        .TIME_BITS (TIME_BITS)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .op      (op_reg),
        .wb      (wb_reg),
        .lvl     (lvl_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_drive_low      = out_reg.drive_low;
    assign m_busy_res       = out_reg.busy;
    assign m_op_done        = out_reg.done;
    assign m_device_present = out_reg.present;
    assign m_read_data      = out_reg.read_data;
    assign m_rejected       = out_reg.rejected;

endmodule

// ===== hw/rtl/owbms_checker.sv =====
// ----------------------------------------------------------------------------
// owbms_checker
// port-level checks of the bus master result stream
// ----------------------------------------------------------------------------
module owbms_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_drive_low,
    input logic       m_busy_res,
    input logic       m_op_done,
    input logic [7:0] m_read_data
);

    // done only on the last busy tick
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_op_done |-> m_busy_res)
        else $error("op_done without busy");

    // bus driven only during an operation
    a_drive_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_drive_low |-> m_busy_res)
        else $error("drive_low while idle");

    // read data shows only on the finishing tick
    a_data_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_read_data != 8'h00) |-> m_op_done)
        else $error("read_data outside done");

    // stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data) && $stable(m_op_done))
        else $error("stalled item changed");

    // reset empties the result stage
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind onewire_bus_master_slots_unit owbms_checker u_owbms_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_drive_low (m_drive_low),
    .m_busy_res  (m_busy_res),
    .m_op_done   (m_op_done),
    .m_read_data (m_read_data)
);
